@@ src/bsu_pkg.sv @@
// Shared types and constants for the background subtraction and update block.
// Depends on nothing; the front, back, top and testbench refer to it by scoped names.

package bsu_pkg;

   // Configuration register set as seen by the datapath.
   typedef struct packed {
      logic [7:0] diff_threshold;
      logic [8:0] blend_alpha;
      logic       selective_mode;
      logic [7:0] ghost_threshold;
   } cfg_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DIFF_THRESHOLD  = 2'd0;
   localparam logic [1:0] REG_BLEND_ALPHA     = 2'd1;
   localparam logic [1:0] REG_SELECTIVE_MODE  = 2'd2;
   localparam logic [1:0] REG_GHOST_THRESHOLD = 2'd3;

   // Reset values of the registers.
   localparam logic [7:0] RST_DIFF_THRESHOLD  = 8'd30;
   localparam logic [8:0] RST_BLEND_ALPHA     = 9'd13;
   localparam logic       RST_SELECTIVE_MODE  = 1'b0;
   localparam logic [7:0] RST_GHOST_THRESHOLD = 8'd100;

   // Alpha of one in Q1.8 and the saturation level of the run counter.
   localparam logic [8:0] ALPHA_ONE = 9'd256;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   // Queue between the front and the back part.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QCNT_W      = 3;

endpackage

@@ src/bsu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.

module bsu_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/bsu_queue.sv @@
// Short first-in first-out queue between the front and the back part.
// Depends on nothing; the depth and count width come from the instantiating module.

module bsu_queue #(
   parameter int unsigned WIDTH  = 25,
   parameter int unsigned DEPTH  = 4,
   parameter int unsigned CNT_W  = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   output logic [CNT_W-1:0] count
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

@@ src/bsu_front.sv @@
// Front part: accepts pixels, reduces the index to a store address and queues them.
// Depends on bsu_pkg for the queue depth and count width.

module bsu_front #(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_pixel_value,
   input  logic [15:0]                         req_pixel_index,
   input  logic                                req_init_frame,
   input  logic [bsu_pkg::QCNT_W-1:0]          q_count,
   output logic                                q_push,
   output logic [$clog2(MAX_PIXELS)+8:0]       q_push_data
);

   localparam int unsigned AW = $clog2(MAX_PIXELS);
   // Reciprocal of the frame size; the quotient it gives is low by at most one.
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MAX_PIXELS));
   localparam logic [39:0] MODC  = 40'(MAX_PIXELS);

   logic        accept;
   logic [47:0] recip_prod;

   logic        f1_valid_ff, f1_valid_in;
   logic [7:0]  f1_pix_ff;
   logic        f1_init_ff;
   logic [15:0] f1_index_ff;
   logic [15:0] f1_quot_ff;

   logic [39:0] quot_mul;
   logic [39:0] rem_raw;
   logic [39:0] rem_fix;

   logic          f2_valid_ff, f2_valid_in;
   logic [7:0]    f2_pix_ff;
   logic          f2_init_ff;
   logic [AW-1:0] f2_addr_ff;

   logic [bsu_pkg::QCNT_W:0] occupancy;

   // Every item in the front already holds a queue slot, so the front's stages never stall.
   assign occupancy = (bsu_pkg::QCNT_W+1)'(q_count)
                    + (bsu_pkg::QCNT_W+1)'(f1_valid_ff)
                    + (bsu_pkg::QCNT_W+1)'(f2_valid_ff);
   assign req_ready = (occupancy < (bsu_pkg::QCNT_W+1)'(bsu_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   assign recip_prod  = 48'(req_pixel_index) * 48'(RECIP);
   assign f1_valid_in = accept;

   assign quot_mul    = 40'(f1_quot_ff) * MODC;
   assign rem_raw     = 40'(f1_index_ff) - quot_mul;
   assign rem_fix     = (rem_raw >= MODC) ? rem_raw - MODC : rem_raw;
   assign f2_valid_in = f1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pix_ff   <= req_pixel_value;
         f1_init_ff  <= req_init_frame;
         f1_index_ff <= req_pixel_index;
         f1_quot_ff  <= recip_prod[47:32];
      end
      if (f1_valid_ff) begin
         f2_pix_ff  <= f1_pix_ff;
         f2_init_ff <= f1_init_ff;
         f2_addr_ff <= rem_fix[AW-1:0];
      end
   end

   assign q_push      = f2_valid_ff;
   assign q_push_data = {f2_init_ff, f2_pix_ff, f2_addr_ff};

endmodule

@@ src/bsu_back.sv @@
// Back part: reads the pixel's stored entry, classifies, blends and writes it back.
// Depends on bsu_pkg for the configuration type and constants, and on bsu_ram.

module bsu_back #(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bsu_pkg::cfg_type               cfg,
   input  logic                           q_valid,
   input  logic [$clog2(MAX_PIXELS)+8:0]  q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_abs_diff,
   output logic                           rsp_foreground
);

   localparam int unsigned AW = $clog2(MAX_PIXELS);

   logic          q_init;
   logic [7:0]    q_pix;
   logic [AW-1:0] q_addr;

   logic          e_valid_ff, e_valid_in;
   logic          e_init_ff;
   logic [7:0]    e_pix_ff;
   logic [AW-1:0] e_addr_ff;
   logic          e_ready;
   logic          e_commit;

   logic          w_valid_ff, w_valid_in;
   logic [AW-1:0] w_addr_ff;
   logic [15:0]   w_data_ff;

   logic [15:0] ram_rdata;
   logic [15:0] entry;
   logic [7:0]  bkg;
   logic [7:0]  cnt;
   logic [7:0]  diff;
   logic        fg;
   logic [8:0]  alpha;
   logic signed [8:0]  delta;
   logic signed [18:0] scaled;
   logic signed [19:0] blend_sum;
   logic [7:0]  blended;
   logic [7:0]  cnt_new;
   logic [7:0]  bkg_new;
   logic        we;
   logic [15:0] wdata;

   logic        out_free;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_abs_diff_ff;
   logic        rsp_foreground_ff;

   assign q_init = q_data[AW+8];
   assign q_pix  = q_data[AW+7:AW];
   assign q_addr = q_data[AW-1:0];

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign e_commit   = e_valid_ff && out_free;
   assign e_ready    = !e_valid_ff || out_free;
   assign q_pop      = q_valid && e_ready;
   assign e_valid_in = q_pop ? 1'b1 : (e_commit ? 1'b0 : e_valid_ff);

   bsu_ram #(
      .WIDTH (16),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (e_addr_ff),
      .wdata (wdata),
      .re    (q_pop),
      .raddr (q_addr),
      .rdata (ram_rdata)
   );

   // The read may coincide with the write of the item ahead, so the latest write is
   // kept aside and takes precedence over the memory on an address match.
   assign entry = (w_valid_ff && (w_addr_ff == e_addr_ff)) ? w_data_ff : ram_rdata;
   assign bkg   = entry[7:0];
   assign cnt   = entry[15:8];

   assign diff = (e_pix_ff > bkg) ? e_pix_ff - bkg : bkg - e_pix_ff;
   assign fg   = diff > cfg.diff_threshold;

   // a*pix + (256-a)*bkg equals 256*bkg + a*(pix-bkg).
   assign alpha     = (cfg.blend_alpha > bsu_pkg::ALPHA_ONE) ? bsu_pkg::ALPHA_ONE
                                                             : cfg.blend_alpha;
   assign delta     = $signed({1'b0, e_pix_ff}) - $signed({1'b0, bkg});
   assign scaled    = $signed({1'b0, alpha}) * delta;
   assign blend_sum = $signed({4'b0000, bkg, 8'h00}) + 20'(scaled) + 20'sd128;
   assign blended   = blend_sum[15:8];

   always_comb begin
      if (!fg) begin
         cnt_new = 8'd0;
      end else if (cnt == bsu_pkg::COUNT_MAX) begin
         cnt_new = bsu_pkg::COUNT_MAX;
      end else begin
         cnt_new = cnt + 8'd1;
      end
      bkg_new = (cnt_new > cfg.ghost_threshold) ? e_pix_ff : blended;

      if (e_init_ff) begin
         we    = e_commit;
         wdata = {8'd0, e_pix_ff};
      end else if (cfg.selective_mode) begin
         we    = e_commit && !fg;
         wdata = {cnt, blended};
      end else begin
         we    = e_commit;
         wdata = {cnt_new, bkg_new};
      end
   end

   assign w_valid_in   = we ? 1'b1 : w_valid_ff;
   assign rsp_valid_in = e_commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_valid_ff   <= e_valid_in;
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_init_ff <= q_init;
         e_pix_ff  <= q_pix;
         e_addr_ff <= q_addr;
      end
      if (we) begin
         w_addr_ff <= e_addr_ff;
         w_data_ff <= wdata;
      end
      if (e_commit) begin
         rsp_abs_diff_ff   <= e_init_ff ? 8'd0 : diff;
         rsp_foreground_ff <= e_init_ff ? 1'b0 : fg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_abs_diff   = rsp_abs_diff_ff;
   assign rsp_foreground = rsp_foreground_ff;

endmodule

@@ src/background_subtract_update_top.sv @@
// Top level of the running-average background subtraction block with its registers.
// Depends on bsu_pkg, bsu_front, bsu_queue and bsu_back.
//
//   Channel   Ports                                   Direction   Moves
//   req       req_valid/ready, pixel, index, init     in          one pixel per transfer
//   rsp       rsp_valid/ready, abs_diff, foreground   out         one result per pixel
//   csr       psel, penable, pwrite, paddr, pwdata    in/out      register access
//
// One pixel per cycle is taken in steady state while results are accepted. A result
// passes through the two index reduction stages, the queue, the store read and the
// output register after its pixel transfer. The per-pixel read, update and write of
// the store set that rate.
// Reset is synchronous and clears the control state and the registers; the stores
// hold no defined value until an init pixel writes them. A stalled result stops the
// back part first, and the front keeps taking pixels until the queue is spoken for.

module background_subtract_update_top #(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_value,
   input  logic [15:0] req_pixel_index,
   input  logic        req_init_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_abs_diff,
   output logic        rsp_foreground,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned IW = $clog2(MAX_PIXELS) + 9;

   bsu_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       reg_index;
   logic             reg_write;

   logic                       q_push;
   logic [IW-1:0]              q_push_data;
   logic                       q_pop;
   logic                       q_valid;
   logic [IW-1:0]              q_data;
   logic [bsu_pkg::QCNT_W-1:0] q_count;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (reg_write) begin
         case (reg_index)
            bsu_pkg::REG_DIFF_THRESHOLD:  cfg_in.diff_threshold  = pwdata[7:0];
            bsu_pkg::REG_BLEND_ALPHA:     cfg_in.blend_alpha     = pwdata[8:0];
            bsu_pkg::REG_SELECTIVE_MODE:  cfg_in.selective_mode  = pwdata[0];
            bsu_pkg::REG_GHOST_THRESHOLD: cfg_in.ghost_threshold = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         bsu_pkg::REG_DIFF_THRESHOLD:  prdata = 32'(cfg_ff.diff_threshold);
         bsu_pkg::REG_BLEND_ALPHA:     prdata = 32'(cfg_ff.blend_alpha);
         bsu_pkg::REG_SELECTIVE_MODE:  prdata = 32'(cfg_ff.selective_mode);
         bsu_pkg::REG_GHOST_THRESHOLD: prdata = 32'(cfg_ff.ghost_threshold);
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.diff_threshold  <= bsu_pkg::RST_DIFF_THRESHOLD;
         cfg_ff.blend_alpha     <= bsu_pkg::RST_BLEND_ALPHA;
         cfg_ff.selective_mode  <= bsu_pkg::RST_SELECTIVE_MODE;
         cfg_ff.ghost_threshold <= bsu_pkg::RST_GHOST_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsu_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .req_pixel_index (req_pixel_index),
      .req_init_frame  (req_init_frame),
      .q_count         (q_count),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   bsu_queue #(
      .WIDTH (IW),
      .DEPTH (bsu_pkg::QUEUE_DEPTH),
      .CNT_W (bsu_pkg::QCNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data),
      .count      (q_count)
   );

   bsu_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_abs_diff   (rsp_abs_diff),
      .rsp_foreground (rsp_foreground)
   );

endmodule

@@ sim/tb_background_subtract_update_top.sv @@
// Testbench for background_subtract_update_top: drives pixels and register writes,
// predicts each abs_diff and foreground flag from its own background and run-length copy.
// Depends on bsu_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_background_subtract_update_top;

   localparam int unsigned STALL_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] abs_diff;
      logic       foreground;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_pixel_value;
   logic [15:0] req_pixel_index;
   logic        req_init_frame;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_abs_diff;
   logic        rsp_foreground;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Copy of the register set and of the per-pixel stores.
   logic [7:0]  cfg_thr;
   logic [8:0]  cfg_alpha;
   logic        cfg_sel;
   logic [7:0]  cfg_ghost;
   logic [7:0]  bg_level [0:65535];
   logic [7:0]  run_len [0:65535];

   pixel_result_type expected_results[$];
   logic [15:0]      hot_index[$];
   int unsigned      sent_pixels;
   int unsigned      mismatches;
   int unsigned      stalled_cycles;
   bit               steady_send;
   bit               steady_recv;

   background_subtract_update_top dut (.*);

   always #1 clock = ~clock;

   task report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [7:0] blend_level(input int unsigned pix, input int unsigned bkg);
      int unsigned a;
      a = (cfg_alpha > 9'd256) ? 256 : 32'(cfg_alpha);
      return 8'((a * pix + (256 - a) * bkg + 128) >> 8);
   endfunction

   // Updates the store copy for one accepted pixel and queues its result.
   task expect_pixel(input logic [7:0] pix, input logic [15:0] idx, input logic init);
      pixel_result_type r;
      int unsigned      bkg;
      int unsigned      diff;
      int unsigned      cnt;
      logic [7:0]       nb;
      logic             fg;
      if (init) begin
         bg_level[idx] = pix;
         run_len[idx] = 8'd0;
         r = '0;
      end else begin
         bkg = 32'(bg_level[idx]);
         diff = (32'(pix) > bkg) ? 32'(pix) - bkg : bkg - 32'(pix);
         fg = diff > 32'(cfg_thr);
         if (cfg_sel) begin
            if (!fg) bg_level[idx] = blend_level(32'(pix), bkg);
         end else begin
            nb = blend_level(32'(pix), bkg);
            cnt = 32'(run_len[idx]);
            if (fg) cnt = (cnt < 32'(bsu_pkg::COUNT_MAX)) ? cnt + 1 : 32'(bsu_pkg::COUNT_MAX);
            else cnt = 0;
            run_len[idx] = 8'(cnt);
            if (cnt > 32'(cfg_ghost)) nb = pix;
            bg_level[idx] = nb;
         end
         r.abs_diff = 8'(diff);
         r.foreground = fg;
      end
      expected_results.push_back(r);
   endtask

   task send_pixel(input logic [7:0] pix, input logic [15:0] idx, input logic init);
      @(negedge clock);
      if (!steady_send) begin
         while ($urandom_range(99) < 24) begin
            req_valid = 1'b0;
            req_pixel_value = 8'($urandom);
            req_pixel_index = 16'($urandom);
            req_init_frame = 1'($urandom);
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_pixel_value = pix;
      req_pixel_index = idx;
      req_init_frame = init;
      do @(posedge clock); while (req_ready !== 1'b1);
      expect_pixel(pix, idx, init);
      sent_pixels++;
   endtask

   // Holds the sender off until every queued result has been transferred.
   task wait_all_results;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task write_register(input logic [1:0] which, input logic [31:0] value);
      logic [31:0] kept;
      case (which)
         bsu_pkg::REG_DIFF_THRESHOLD: kept = value & 32'h0000_00FF;
         bsu_pkg::REG_BLEND_ALPHA:    kept = value & 32'h0000_01FF;
         bsu_pkg::REG_SELECTIVE_MODE: kept = value & 32'h0000_0001;
         default:                     kept = value & 32'h0000_00FF;
      endcase
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {which, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (which)
         bsu_pkg::REG_DIFF_THRESHOLD: cfg_thr = kept[7:0];
         bsu_pkg::REG_BLEND_ALPHA:    cfg_alpha = kept[8:0];
         bsu_pkg::REG_SELECTIVE_MODE: cfg_sel = kept[0];
         default:                     cfg_ghost = kept[7:0];
      endcase
      // Read the register back through a second transfer.
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== kept)
         report_mismatch($sformatf("register %0d read %h, written %h", which, prdata, kept));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // Upper bits of each write are random so that masking is exercised.
   task set_config(input logic [7:0] thr, input logic [8:0] alpha, input logic sel,
                   input logic [7:0] ghost);
      logic [31:0] junk;
      junk = $urandom;
      write_register(bsu_pkg::REG_DIFF_THRESHOLD, {junk[31:8], thr});
      junk = $urandom;
      write_register(bsu_pkg::REG_BLEND_ALPHA, {junk[31:9], alpha});
      junk = $urandom;
      write_register(bsu_pkg::REG_SELECTIVE_MODE, {junk[31:1], sel});
      junk = $urandom;
      write_register(bsu_pkg::REG_GHOST_THRESHOLD, {junk[31:8], ghost});
   endtask

   // Near pixels straddle the threshold; far pixels build long foreground runs.
   function automatic logic [7:0] pick_pixel(input int bkg, input bit far);
      int p;
      int span;
      span = int'(cfg_thr) + 2;
      if (far) begin
         p = (bkg < 128) ? int'($urandom_range(255, 200)) : int'($urandom_range(55, 0));
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3: p = bkg + int'($urandom_range(2 * span)) - span;
            4, 5, 6:    p = int'($urandom_range(255));
            7:          p = 0;
            8:          p = 255;
            default:    p = bkg;
         endcase
      end
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      return 8'(p);
   endfunction

   task test_reset_values;
      send_pixel(8'd0, 16'h0000, 1'b1);
      send_pixel(8'd255, 16'hFFFF, 1'b1);
      send_pixel(8'h55, 16'h5555, 1'b1);
      send_pixel(8'hAA, 16'hAAAA, 1'b1);
      send_pixel(8'd255, 16'h0000, 1'b0);
      send_pixel(8'd0, 16'hFFFF, 1'b0);
      send_pixel(8'h55, 16'h5555, 1'b0);
      // Difference exactly at the threshold stays background, one above is foreground.
      send_pixel(bg_level[16'hAAAA] + cfg_thr, 16'hAAAA, 1'b0);
      send_pixel(bg_level[16'hAAAA] - cfg_thr - 8'd1, 16'hAAAA, 1'b0);
      // Loading a pixel again clears its run counter.
      send_pixel(8'd128, 16'h0000, 1'b1);
      send_pixel(8'd128, 16'h0000, 1'b0);
   endtask

   task test_register_extremes;
      wait_all_results;
      set_config(8'd0, bsu_pkg::ALPHA_ONE, 1'b0, 8'd0);
      send_pixel(bg_level[16'h5555] + 8'd1, 16'h5555, 1'b0);
      send_pixel(bg_level[16'h5555], 16'h5555, 1'b0);
      send_pixel(8'd255, 16'hFFFF, 1'b0);
      wait_all_results;
      // Alpha above one acts as one.
      set_config(8'd255, 9'd511, 1'b0, 8'd255);
      send_pixel(8'd0, 16'hAAAA, 1'b0);
      send_pixel(8'd255, 16'hAAAA, 1'b0);
      wait_all_results;
      set_config(8'd10, 9'd128, 1'b1, 8'd100);
      send_pixel(8'd255, 16'h0000, 1'b0);
      send_pixel(bg_level[16'h0000] + 8'd5, 16'h0000, 1'b0);
      send_pixel(bg_level[16'h0000], 16'h0000, 1'b0);
      wait_all_results;
      set_config(8'd30, 9'd0, 1'b1, 8'd100);
      send_pixel(bg_level[16'h5555] + 8'd3, 16'h5555, 1'b0);
   endtask

   task test_random_traffic(input logic [7:0] thr, input logic [8:0] alpha, input logic sel,
                            input logic [7:0] ghost, input int unsigned count, input bit steady);
      int unsigned target;
      int unsigned halfway;
      bit          paused;
      bit          far;
      logic [15:0] idx;
      wait_all_results;
      set_config(thr, alpha, sel, ghost);
      steady_send = steady;
      steady_recv = steady;
      if (hot_index.size() == 0) begin
         hot_index.push_back(16'h0000);
         hot_index.push_back(16'hFFFF);
         repeat (22) hot_index.push_back(16'($urandom));
         foreach (hot_index[i]) send_pixel(8'($urandom), hot_index[i], 1'b1);
      end
      target = sent_pixels + count;
      halfway = sent_pixels + count / 2;
      paused = 1'b0;
      while (sent_pixels < target) begin
         if (!paused && sent_pixels >= halfway) begin
            wait_all_results;
            paused = 1'b1;
         end
         idx = hot_index[$urandom_range(hot_index.size() - 1)];
         if ($urandom_range(99) < 6) begin
            send_pixel(8'($urandom), idx, 1'b1);
         end else begin
            far = 1'($urandom_range(1));
            repeat ($urandom_range(8, 1))
               send_pixel(pick_pixel(int'(bg_level[idx]), far), idx, 1'b0);
         end
      end
      steady_send = 1'b0;
      steady_recv = 1'b0;
   endtask

   // A frozen background and a zero threshold drive one counter into saturation,
   // then a lower ghost threshold lets the pixel replace the background.
   task test_counter_saturation;
      logic [7:0] last;
      wait_all_results;
      set_config(8'd0, 9'd0, 1'b0, bsu_pkg::COUNT_MAX);
      send_pixel(8'd0, 16'h1234, 1'b1);
      repeat (270) send_pixel(8'($urandom_range(255, 1)), 16'h1234, 1'b0);
      wait_all_results;
      set_config(8'd0, 9'd0, 1'b0, 8'd254);
      last = 8'($urandom_range(255, 1));
      send_pixel(last, 16'h1234, 1'b0);
      send_pixel(last, 16'h1234, 1'b0);
      send_pixel(8'd0, 16'h1234, 1'b0);
   endtask

   always @(negedge clock) begin
      rsp_ready = steady_recv || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transfer with no pixel outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_abs_diff !== want.abs_diff)
               report_mismatch($sformatf("abs_diff %0d, expected %0d",
                                         rsp_abs_diff, want.abs_diff));
            if (rsp_foreground !== want.foreground)
               report_mismatch($sformatf("foreground %b, expected %b",
                                         rsp_foreground, want.foreground));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_value = 8'd0;
      req_pixel_index = 16'd0;
      req_init_frame = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 4'd0;
      pwdata = 32'd0;
      cfg_thr = bsu_pkg::RST_DIFF_THRESHOLD;
      cfg_alpha = bsu_pkg::RST_BLEND_ALPHA;
      cfg_sel = bsu_pkg::RST_SELECTIVE_MODE;
      cfg_ghost = bsu_pkg::RST_GHOST_THRESHOLD;
      sent_pixels = 0;
      mismatches = 0;
      stalled_cycles = 0;
      steady_send = 1'b0;
      steady_recv = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values;
      test_register_extremes;
      test_random_traffic(8'd20, 9'd64, 1'b0, 8'd3, 135, 1'b1);
      test_random_traffic(8'd0, bsu_pkg::ALPHA_ONE, 1'b0, 8'd0, 135, 1'b0);
      test_random_traffic(8'd255, 9'd511, 1'b1, 8'd255, 135, 1'b0);
      test_random_traffic(8'd40, 9'd300, 1'b0, 8'd5, 135, 1'b0);
      test_random_traffic(8'($urandom), 9'($urandom), 1'($urandom), 8'($urandom), 135, 1'b0);
      test_random_traffic(8'd10, 9'd1, 1'b1, 8'd50, 135, 1'b0);
      test_counter_saturation;

      wait_all_results;
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
